// File: hdl/jdc_pkg.sv
// shared types, constants and codes of the joystick direction classifier
`default_nettype none

package jdc_pkg;

  localparam int unsigned ADC_FULL_SCALE = 4096;

  localparam int unsigned NUM_CH   = 4;
  localparam int unsigned RAW_W    = 12;
  localparam int unsigned MV_W     = 13;
  localparam int unsigned MUL_W    = 13;
  localparam int unsigned RATIO_W  = 8;
  localparam int unsigned CALIB_W  = 10;
  localparam int unsigned LEVEL_W  = 16;
  localparam int unsigned DIR_W    = 4;
  localparam int unsigned PHASE_W  = 2;
  localparam int unsigned PROD_W   = MV_W + MUL_W;
  localparam int unsigned CNT_W    = $clog2(PROD_W + 1);

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_START_MV      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CALIB_SAMPLES = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIG_MUL      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIG_DIV      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DIAG_MUL      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DIAG_DIV      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_VREF_MV       = 3'd6;

  localparam logic [MV_W-1:0]    RST_START_MV      = 13'd300;
  localparam logic [CALIB_W-1:0] RST_CALIB_SAMPLES = 10'd300;
  localparam logic [RATIO_W-1:0] RST_TRIG_MUL      = 8'd1;
  localparam logic [RATIO_W-1:0] RST_TRIG_DIV      = 8'd2;
  localparam logic [RATIO_W-1:0] RST_DIAG_MUL      = 8'd1;
  localparam logic [RATIO_W-1:0] RST_DIAG_DIV      = 8'd3;
  localparam logic [MV_W-1:0]    RST_VREF_MV       = 13'd3300;

  localparam logic [MV_W-1:0]    MV_MAX    = 13'h1FFF;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 16'hFFFF;

  typedef enum logic [DIR_W-1:0] {
    DIR_NONE = 4'd0,
    DIR_L    = 4'd1,
    DIR_U    = 4'd2,
    DIR_R    = 4'd3,
    DIR_D    = 4'd4,
    DIR_LU   = 4'd5,
    DIR_RU   = 4'd6,
    DIR_LD   = 4'd7,
    DIR_RD   = 4'd8
  } dir_e;

  typedef enum logic [PHASE_W-1:0] {
    PH_NORMAL  = 2'd0,
    PH_ARMED   = 2'd1,
    PH_COLLECT = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    TS_IDLE,
    TS_SCALE,
    TS_TRIG,
    TS_DIAG,
    TS_DONE
  } top_st_e;

  typedef enum logic [1:0] {
    LN_IDLE,
    LN_MUL,
    LN_DIV
  } lane_st_e;

  typedef struct packed {
    logic             start;
    logic [MV_W-1:0]  x;
    logic [MUL_W-1:0] m;
  } lane_cmd_t;

endpackage

`default_nettype wire

// File: hdl/jdc_if.sv
// word channels of the joystick direction classifier
`default_nettype none

interface jdc_in_if;
  logic                       valid;
  logic                       ready;
  logic                       func;
  logic [jdc_pkg::RAW_W-1:0]  raw_left;
  logic [jdc_pkg::RAW_W-1:0]  raw_up;
  logic [jdc_pkg::RAW_W-1:0]  raw_right;
  logic [jdc_pkg::RAW_W-1:0]  raw_down;

  modport source (output valid, func, raw_left, raw_up, raw_right, raw_down, input ready);
  modport sink   (input valid, func, raw_left, raw_up, raw_right, raw_down, output ready);
endinterface

interface jdc_out_if;
  logic                         valid;
  logic                         ready;
  logic [jdc_pkg::DIR_W-1:0]    direction;
  logic [jdc_pkg::MV_W-1:0]     mv_left;
  logic [jdc_pkg::MV_W-1:0]     mv_up;
  logic [jdc_pkg::MV_W-1:0]     mv_right;
  logic [jdc_pkg::MV_W-1:0]     mv_down;
  logic [jdc_pkg::PHASE_W-1:0]  phase;

  modport source (output valid, direction, mv_left, mv_up, mv_right, mv_down, phase,
                  input ready);
  modport sink   (input valid, direction, mv_left, mv_up, mv_right, mv_down, phase,
                  output ready);
endinterface

`default_nettype wire

// File: hdl/jdc_lane.sv
// bit-serial multiply then restoring divide lane: quot = x * m / div
`default_nettype none

module jdc_lane #(
  parameter int unsigned DivW = $clog2(jdc_pkg::ADC_FULL_SCALE + 1)
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire jdc_pkg::lane_cmd_t          cmd_i,
  input  wire logic [DivW-1:0]             div_i,
  output logic                             done_o,
  output logic [jdc_pkg::PROD_W-1:0]       quot_o
);

  localparam int unsigned ProdW = jdc_pkg::PROD_W;
  localparam int unsigned MulW  = jdc_pkg::MUL_W;
  localparam int unsigned CntW  = jdc_pkg::CNT_W;

  jdc_pkg::lane_st_e st_q, st_d;

  logic [CntW-1:0]          cnt_q, cnt_d;
  logic [ProdW-1:0]         acc_q, acc_d;
  logic [jdc_pkg::MV_W-1:0] x_q, x_d;
  logic [MulW-1:0]          m_q, m_d;
  logic [DivW-1:0]          d_q, d_d;
  logic [DivW-1:0]          rem_q, rem_d;
  logic                     done_q, done_d;

  logic             last_mul;
  logic             last_div;
  logic [DivW:0]    trial;
  logic [DivW:0]    diff;
  logic             ge;

  assign last_mul = (cnt_q == CntW'(MulW - 1));
  assign last_div = (cnt_q == CntW'(ProdW - 1));
  assign trial    = {rem_q, acc_q[ProdW-1]};
  assign ge       = (trial >= {1'b0, d_q});
  assign diff     = trial - {1'b0, d_q};

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      jdc_pkg::LN_IDLE: begin
        if (cmd_i.start) st_d = jdc_pkg::LN_MUL;
      end
      jdc_pkg::LN_MUL: begin
        if (last_mul) st_d = jdc_pkg::LN_DIV;
      end
      jdc_pkg::LN_DIV: begin
        if (last_div) st_d = jdc_pkg::LN_IDLE;
      end
      default: st_d = jdc_pkg::LN_IDLE;
    endcase
  end

  always_comb begin
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    x_d    = x_q;
    m_d    = m_q;
    d_d    = d_q;
    rem_d  = rem_q;
    done_d = 1'b0;
    unique case (st_q)
      jdc_pkg::LN_IDLE: begin
        if (cmd_i.start) begin
          x_d   = cmd_i.x;
          m_d   = cmd_i.m;
          d_d   = div_i;
          acc_d = '0;
          cnt_d = '0;
        end
      end
      jdc_pkg::LN_MUL: begin
        acc_d = {acc_q[ProdW-2:0], 1'b0} + (m_q[MulW-1] ? ProdW'(x_q) : '0);
        m_d   = {m_q[MulW-2:0], 1'b0};
        rem_d = '0;
        cnt_d = last_mul ? '0 : cnt_q + 1'b1;
      end
      jdc_pkg::LN_DIV: begin
        acc_d  = {acc_q[ProdW-2:0], ge};
        rem_d  = ge ? diff[DivW-1:0] : trial[DivW-1:0];
        cnt_d  = cnt_q + 1'b1;
        done_d = last_div;
      end
      default: begin
        done_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= jdc_pkg::LN_IDLE;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    x_q   <= x_d;
    m_q   <= m_d;
    d_q   <= d_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign quot_o = acc_q;

endmodule

`default_nettype wire

// File: hdl/joystick_direction_classifier.sv
// joystick direction classifier: top level with calibration control and output register
// a sample word holds off the next accept until its result is loaded into the output register; four serial lanes
// each run a 13-step multiply and a 26-step divide to scale the channels to millivolts
// a sample that closes the calibration window adds two more lane passes
// a start word skips the lanes; a new word is taken while the last result waits downstream
// reset: asynchronous active low, registers at their reset values, phase normal, levels zero
`default_nettype none

module joystick_direction_classifier #(
  parameter int unsigned AdcFullScale = jdc_pkg::ADC_FULL_SCALE
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  jdc_in_if.sink                                 in_i,
  jdc_out_if.source                              out_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [jdc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [jdc_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);

  localparam int unsigned DivW   = $clog2(AdcFullScale + 1);
  localparam int unsigned NumCh  = jdc_pkg::NUM_CH;
  localparam int unsigned MvW    = jdc_pkg::MV_W;
  localparam int unsigned LevelW = jdc_pkg::LEVEL_W;
  localparam int unsigned ProdW  = jdc_pkg::PROD_W;
  localparam int unsigned RatioW = jdc_pkg::RATIO_W;
  localparam int unsigned CalibW = jdc_pkg::CALIB_W;

  // configuration registers
  logic [MvW-1:0]    start_mv_q;
  logic [CalibW-1:0] calib_samples_q;
  logic [RatioW-1:0] trig_mul_q;
  logic [RatioW-1:0] trig_div_q;
  logic [RatioW-1:0] diag_mul_q;
  logic [RatioW-1:0] diag_div_q;
  logic [MvW-1:0]    vref_mv_q;

  jdc_pkg::top_st_e  st_q, st_d;
  jdc_pkg::phase_e   phase_q, phase_d;
  logic [CalibW-1:0] window_q, window_d;
  logic [MvW-1:0]    chan_max_q [NumCh];
  logic [MvW-1:0]    chan_max_d [NumCh];
  logic [LevelW-1:0] trig_q [NumCh];
  logic [LevelW-1:0] trig_d [NumCh];
  logic [LevelW-1:0] diag_q [NumCh];
  logic [LevelW-1:0] diag_d [NumCh];

  jdc_pkg::dir_e     res_dir_q, res_dir_d;
  logic [MvW-1:0]    res_mv_q [NumCh];
  logic [MvW-1:0]    res_mv_d [NumCh];
  jdc_pkg::phase_e   res_phase_q, res_phase_d;

  logic                        out_valid_q;
  jdc_pkg::dir_e               out_dir_q;
  logic [MvW-1:0]              out_mv_q [NumCh];
  jdc_pkg::phase_e             out_phase_q;

  jdc_pkg::lane_cmd_t          cmd [NumCh];
  logic [DivW-1:0]             cmd_div;
  logic [NumCh-1:0]            ln_done;
  logic [ProdW-1:0]            ln_quot [NumCh];

  logic [MvW-1:0]              mv_sat [NumCh];
  logic [LevelW-1:0]           lvl_sat [NumCh];
  logic [jdc_pkg::RAW_W-1:0]   raw [NumCh];

  logic                        accept;
  logic                        lanes_done;
  logic                        out_load;
  logic                        start_hit;
  logic [CalibW-1:0]           win_inc;
  logic                        fin;
  logic [NumCh-1:0]            pair_hit;
  jdc_pkg::dir_e               dir_calc;

  assign raw[0] = in_i.raw_left;
  assign raw[1] = in_i.raw_up;
  assign raw[2] = in_i.raw_right;
  assign raw[3] = in_i.raw_down;

  assign in_i.ready = (st_q == jdc_pkg::TS_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign lanes_done = &ln_done;
  assign out_load   = (st_q == jdc_pkg::TS_DONE) && (!out_valid_q || out_o.ready);

  for (genvar g = 0; g < NumCh; g++) begin : g_lane
    jdc_lane #(
      .DivW (DivW)
    ) u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (cmd[g]),
      .div_i  (cmd_div),
      .done_o (ln_done[g]),
      .quot_o (ln_quot[g])
    );

    assign mv_sat[g]  = (|ln_quot[g][ProdW-1:MvW]) ? jdc_pkg::MV_MAX : ln_quot[g][MvW-1:0];
    assign lvl_sat[g] = (|ln_quot[g][ProdW-1:LevelW]) ? jdc_pkg::LEVEL_MAX
                                                       : ln_quot[g][LevelW-1:0];
  end

  assign start_hit = (mv_sat[0] > start_mv_q) || (mv_sat[1] > start_mv_q)
                  || (mv_sat[2] > start_mv_q) || (mv_sat[3] > start_mv_q);
  assign win_inc   = window_q + 1'b1;
  assign fin       = ((phase_q == jdc_pkg::PH_ARMED) && start_hit && (calib_samples_q == '0))
                  || ((phase_q == jdc_pkg::PH_COLLECT) && (win_inc >= calib_samples_q));

  // diagonal pairs: L+U, R+U, L+D, R+D
  assign pair_hit[0] = (LevelW'(mv_sat[0]) > diag_q[0]) && (LevelW'(mv_sat[1]) > diag_q[1]);
  assign pair_hit[1] = (LevelW'(mv_sat[2]) > diag_q[2]) && (LevelW'(mv_sat[1]) > diag_q[1]);
  assign pair_hit[2] = (LevelW'(mv_sat[0]) > diag_q[0]) && (LevelW'(mv_sat[3]) > diag_q[3]);
  assign pair_hit[3] = (LevelW'(mv_sat[2]) > diag_q[2]) && (LevelW'(mv_sat[3]) > diag_q[3]);

  always_comb begin
    dir_calc = jdc_pkg::DIR_NONE;
    if ($onehot(pair_hit)) begin
      priority if (pair_hit[0]) dir_calc = jdc_pkg::DIR_LU;
      else if (pair_hit[1])     dir_calc = jdc_pkg::DIR_RU;
      else if (pair_hit[2])     dir_calc = jdc_pkg::DIR_LD;
      else                      dir_calc = jdc_pkg::DIR_RD;
    end else begin
      if (LevelW'(mv_sat[0]) > trig_q[0])      dir_calc = jdc_pkg::DIR_L;
      else if (LevelW'(mv_sat[1]) > trig_q[1]) dir_calc = jdc_pkg::DIR_U;
      else if (LevelW'(mv_sat[2]) > trig_q[2]) dir_calc = jdc_pkg::DIR_R;
      else if (LevelW'(mv_sat[3]) > trig_q[3]) dir_calc = jdc_pkg::DIR_D;
      else                                     dir_calc = jdc_pkg::DIR_NONE;
    end
  end

  // next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      jdc_pkg::TS_IDLE: begin
        if (accept) st_d = in_i.func ? jdc_pkg::TS_DONE : jdc_pkg::TS_SCALE;
      end
      jdc_pkg::TS_SCALE: begin
        if (lanes_done) st_d = fin ? jdc_pkg::TS_TRIG : jdc_pkg::TS_DONE;
      end
      jdc_pkg::TS_TRIG: begin
        if (lanes_done) st_d = jdc_pkg::TS_DIAG;
      end
      jdc_pkg::TS_DIAG: begin
        if (lanes_done) st_d = jdc_pkg::TS_DONE;
      end
      jdc_pkg::TS_DONE: begin
        if (out_load) st_d = jdc_pkg::TS_IDLE;
      end
      default: st_d = jdc_pkg::TS_IDLE;
    endcase
  end

  // lane commands and state updates
  always_comb begin
    phase_d     = phase_q;
    window_d    = window_q;
    res_dir_d   = res_dir_q;
    res_phase_d = res_phase_q;
    cmd_div     = DivW'(AdcFullScale);
    for (int i = 0; i < NumCh; i++) begin
      chan_max_d[i] = chan_max_q[i];
      trig_d[i]     = trig_q[i];
      diag_d[i]     = diag_q[i];
      res_mv_d[i]   = res_mv_q[i];
      cmd[i].start  = 1'b0;
      cmd[i].x      = MvW'(raw[i]);
      cmd[i].m      = jdc_pkg::MUL_W'(vref_mv_q);
    end

    unique case (st_q)
      jdc_pkg::TS_IDLE: begin
        if (accept) begin
          if (in_i.func) begin
            phase_d     = jdc_pkg::PH_ARMED;
            window_d    = '0;
            res_dir_d   = jdc_pkg::DIR_NONE;
            res_phase_d = jdc_pkg::PH_ARMED;
            for (int i = 0; i < NumCh; i++) begin
              chan_max_d[i] = '0;
              res_mv_d[i]   = '0;
            end
          end else begin
            for (int i = 0; i < NumCh; i++) cmd[i].start = 1'b1;
          end
        end
      end
      jdc_pkg::TS_SCALE: begin
        if (lanes_done) begin
          res_dir_d = jdc_pkg::DIR_NONE;
          for (int i = 0; i < NumCh; i++) res_mv_d[i] = mv_sat[i];
          unique case (phase_q)
            jdc_pkg::PH_ARMED: begin
              if (start_hit) begin
                phase_d  = jdc_pkg::PH_COLLECT;
                window_d = '0;
              end
            end
            jdc_pkg::PH_COLLECT: begin
              window_d = win_inc;
              for (int i = 0; i < NumCh; i++) begin
                if (mv_sat[i] > chan_max_q[i]) chan_max_d[i] = mv_sat[i];
              end
            end
            default: begin
              phase_d   = jdc_pkg::PH_NORMAL;
              res_dir_d = dir_calc;
            end
          endcase
          if (fin) begin
            phase_d = jdc_pkg::PH_NORMAL;
            cmd_div = DivW'(trig_div_q);
            for (int i = 0; i < NumCh; i++) begin
              cmd[i].start = 1'b1;
              cmd[i].x     = chan_max_d[i];
              cmd[i].m     = jdc_pkg::MUL_W'(trig_mul_q);
            end
          end
          res_phase_d = phase_d;
        end
      end
      jdc_pkg::TS_TRIG: begin
        if (lanes_done) begin
          cmd_div = DivW'(diag_div_q);
          for (int i = 0; i < NumCh; i++) begin
            trig_d[i]    = lvl_sat[i];
            cmd[i].start = 1'b1;
            cmd[i].x     = chan_max_q[i];
            cmd[i].m     = jdc_pkg::MUL_W'(diag_mul_q);
          end
        end
      end
      jdc_pkg::TS_DIAG: begin
        if (lanes_done) begin
          for (int i = 0; i < NumCh; i++) diag_d[i] = lvl_sat[i];
        end
      end
      jdc_pkg::TS_DONE: begin
        res_phase_d = res_phase_q;
      end
      default: begin
        res_phase_d = res_phase_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= jdc_pkg::TS_IDLE;
      phase_q     <= jdc_pkg::PH_NORMAL;
      window_q    <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NumCh; i++) begin
        chan_max_q[i] <= '0;
        trig_q[i]     <= '0;
        diag_q[i]     <= '0;
      end
    end else begin
      st_q     <= st_d;
      phase_q  <= phase_d;
      window_q <= window_d;
      for (int i = 0; i < NumCh; i++) begin
        chan_max_q[i] <= chan_max_d[i];
        trig_q[i]     <= trig_d[i];
        diag_q[i]     <= diag_d[i];
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_mv_q      <= jdc_pkg::RST_START_MV;
      calib_samples_q <= jdc_pkg::RST_CALIB_SAMPLES;
      trig_mul_q      <= jdc_pkg::RST_TRIG_MUL;
      trig_div_q      <= jdc_pkg::RST_TRIG_DIV;
      diag_mul_q      <= jdc_pkg::RST_DIAG_MUL;
      diag_div_q      <= jdc_pkg::RST_DIAG_DIV;
      vref_mv_q       <= jdc_pkg::RST_VREF_MV;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        jdc_pkg::CFG_START_MV:      start_mv_q      <= cfg_wdata_i[MvW-1:0];
        jdc_pkg::CFG_CALIB_SAMPLES: calib_samples_q <= cfg_wdata_i[CalibW-1:0];
        jdc_pkg::CFG_TRIG_MUL:      trig_mul_q      <= cfg_wdata_i[RatioW-1:0];
        jdc_pkg::CFG_TRIG_DIV:      trig_div_q      <= cfg_wdata_i[RatioW-1:0];
        jdc_pkg::CFG_DIAG_MUL:      diag_mul_q      <= cfg_wdata_i[RatioW-1:0];
        jdc_pkg::CFG_DIAG_DIV:      diag_div_q      <= cfg_wdata_i[RatioW-1:0];
        jdc_pkg::CFG_VREF_MV:       vref_mv_q       <= cfg_wdata_i[MvW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    res_dir_q   <= res_dir_d;
    res_phase_q <= res_phase_d;
    for (int i = 0; i < NumCh; i++) res_mv_q[i] <= res_mv_d[i];
    if (out_load) begin
      out_dir_q   <= res_dir_q;
      out_phase_q <= res_phase_q;
      for (int i = 0; i < NumCh; i++) out_mv_q[i] <= res_mv_q[i];
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.direction = out_dir_q;
  assign out_o.mv_left   = out_mv_q[0];
  assign out_o.mv_up     = out_mv_q[1];
  assign out_o.mv_right  = out_mv_q[2];
  assign out_o.mv_down   = out_mv_q[3];
  assign out_o.phase     = out_phase_q;

endmodule

`default_nettype wire
